@@ sv/ducv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ducv_pkg;

  localparam int unsigned NumStages = 7;

  localparam logic [30:0] Epoch1980      = 31'd315532800;
  localparam logic [15:0] DaysTo1980Plus = 16'd3653;
  localparam logic [14:0] DaysTo1980     = 15'd3652;
  localparam logic [16:0] SecsPerDay     = 17'd86400;
  localparam logic [11:0] SecsPerHour    = 12'd3600;
  localparam logic [8:0]  DaysPerYear    = 9'd365;
  localparam logic [5:0]  SecsPerMin     = 6'd60;

  // reciprocals, exact for the operand ranges they see
  // day:  (u >> 7) / 675, 24-bit operand, shift 34
  // hour: (r >> 4) / 225, 13-bit operand, shift 21
  // min:  (r >> 2) / 15, 10-bit operand, shift 14
  // year: d / 365, 15-bit operand, shift 24
  localparam logic [24:0] DayRecip  = 25'd25451659;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip  = 11'd1093;
  localparam logic [15:0] YearRecip = 16'd45965;

  typedef enum logic {
    OpDosToUnix = 1'b0,
    OpUnixToDos = 1'b1
  } ducv_op_e;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic                 last_valid;
    ducv_op_e             last_op;
  } ducv_ctrl_t;

  // cumulative days before each month, unused codes count zero
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/ducv_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ducv_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [15:0]        dos_time;
  logic [15:0]        dos_date;
  logic signed [31:0] unix_seconds;

  modport source (output valid, operation, dos_time, dos_date, unix_seconds, input ready);
  modport sink (input valid, operation, dos_time, dos_date, unix_seconds, output ready);
endinterface

interface ducv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] unix_seconds_out;
  logic [15:0]        dos_time_out;
  logic [15:0]        dos_date_out;

  modport source (output valid, unix_seconds_out, dos_time_out, dos_date_out, input ready);
  modport sink (input valid, unix_seconds_out, dos_time_out, dos_date_out, output ready);
endinterface

`default_nettype wire

@@ sv/ducv_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ducv_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire ducv_pkg::ducv_op_e in_op_i,
  input  wire logic              out_ready_i,
  output logic                   in_ready_o,
  output ducv_pkg::ducv_ctrl_t   ctrl_o
);
  import ducv_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  ducv_op_e             op_q [NumStages];

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op_q[0] <= in_op_i;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        op_q[i] <= op_q[i-1];
      end
    end
  end

  assign in_ready_o        = en[0];
  assign ctrl_o.en         = en;
  assign ctrl_o.last_valid = valid_q[NumStages-1];
  assign ctrl_o.last_op    = op_q[NumStages-1];

endmodule

`default_nettype wire

@@ sv/ducv_d2u.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ducv_d2u (
  input  wire logic                 clk_i,
  input  wire ducv_pkg::ducv_ctrl_t ctrl_i,
  input  wire logic [15:0]          dos_time_i,
  input  wire logic [15:0]          dos_date_i,
  input  wire logic [31:0]          tz_off_i,
  output logic [31:0]               result_o
);
  import ducv_pkg::*;

  logic [3:0]  mon;
  logic [6:0]  year;
  logic        leap_fix;
  logic [15:0] days_d, days_q;
  logic [16:0] tsec_d, tsec_q;
  logic [31:0] secs_d, secs_q;
  logic [31:0] pipe_q [2:NumStages-1];

  // month zero wraps to an empty table entry
  always_comb begin
    mon      = dos_date_i[8:5] - 4'd1;
    year     = dos_date_i[15:9];
    leap_fix = (year[1:0] == 2'b00) && (mon < 4'd2);
    days_d   = 16'(dos_date_i[4:0]) + 16'(month_start(mon)) + 16'(year[6:2])
             + 16'(year) * 16'(DaysPerYear) + DaysTo1980Plus - 16'd1 - 16'(leap_fix);
    tsec_d   = 17'({dos_time_i[4:0], 1'b0}) + 17'(dos_time_i[10:5]) * 17'(SecsPerMin)
             + 17'(dos_time_i[15:11]) * 17'(SecsPerHour);
  end

  assign secs_d = 32'(days_q) * 32'(SecsPerDay) + 32'(tsec_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      days_q <= days_d;
      tsec_q <= tsec_d;
    end
    if (ctrl_i.en[1]) begin
      secs_q <= secs_d;
    end
    if (ctrl_i.en[2]) begin
      pipe_q[2] <= secs_q + tz_off_i;
    end
    // delay line to line up with the other direction
    for (int i = 3; i < NumStages; i++) begin
      if (ctrl_i.en[i]) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign result_o = pipe_q[NumStages-1];

endmodule

`default_nettype wire

@@ sv/ducv_u2d.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ducv_u2d (
  input  wire logic                 clk_i,
  input  wire ducv_pkg::ducv_ctrl_t ctrl_i,
  input  wire logic signed [31:0]   unix_seconds_i,
  input  wire logic [31:0]          tz_off_i,
  output logic [15:0]               dos_time_o,
  output logic [15:0]               dos_date_o
);
  import ducv_pkg::*;

  function automatic logic [14:0] years_before(input logic [5:0] y);
    logic [6:0] y3;
    y3 = 7'(y) + 7'd3;
    return 15'(y3[6:2]) + 15'(y) * 15'(DaysPerYear);
  endfunction

  // stage 0: offset and clamp
  logic [31:0] diff;
  logic [30:0] u0_d, u0_q;
  // stage 1: day number
  logic [48:0] dprod;
  logic [30:0] u1_q;
  logic [14:0] qd1_q;
  // stage 2: seconds of day, days since 1980
  logic [30:0] qsec;
  logic [30:0] rem2_full;
  logic [16:0] rem2_q;
  logic [14:0] day2_q;
  // stage 3: hour, year estimate
  logic [26:0] hprod;
  logic [30:0] yprod;
  logic [16:0] rem3_q;
  logic [14:0] day3_q;
  logic [4:0]  hrs3_q;
  logic [5:0]  year3_q;
  // stage 4: seconds of hour, days before year
  logic [16:0] rem4_full;
  logic [11:0] rem4_q;
  logic [4:0]  hrs4_q;
  logic [5:0]  year4_q;
  logic [14:0] day4_q;
  logic [14:0] bef4_q;
  // stage 5: minute, year fix, day of year
  logic [20:0] mprod;
  logic        dec;
  logic [5:0]  year5_d, year5_q;
  logic [14:0] bef5;
  logic [14:0] dday5_full;
  logic [11:0] rem5_q;
  logic [4:0]  hrs5_q;
  logic [5:0]  mins5_q;
  logic [9:0]  dday5_q;
  // stage 6: pack
  logic [11:0] secs_full;
  logic        leap;
  logic        feb29;
  logic [9:0]  nl;
  logic [3:0]  mon;
  logic [15:0] time6_d, time6_q;
  logic [15:0] date6_d, date6_q;

  always_comb begin
    diff = $unsigned(unix_seconds_i) - tz_off_i;
    if (diff[31] || (diff[30:0] < Epoch1980)) begin
      u0_d = Epoch1980;
    end else begin
      u0_d = diff[30:0];
    end
  end

  assign dprod = 49'(u0_q[30:7]) * 49'(DayRecip);

  assign qsec      = 31'(qd1_q) * 31'(SecsPerDay);
  assign rem2_full = u1_q - qsec;

  assign hprod = 27'(rem2_q[16:4]) * 27'(HourRecip);
  assign yprod = 31'(day2_q) * 31'(YearRecip);

  assign rem4_full = rem3_q - 17'(hrs3_q) * 17'(SecsPerHour);

  // the estimate may sit one year late near the year boundary
  always_comb begin
    mprod      = 21'(rem4_q[11:2]) * 21'(MinRecip);
    dec        = (bef4_q > day4_q) && (year4_q != 6'd0);
    year5_d    = dec ? year4_q - 6'd1 : year4_q;
    bef5       = dec ? years_before(year5_d) : bef4_q;
    dday5_full = day4_q - bef5;
  end

  always_comb begin
    secs_full = rem5_q - 12'(mins5_q) * 12'(SecsPerMin);
    leap      = (year5_q[1:0] == 2'b00);
    feb29     = (dday5_q == 10'd59) && leap;
    nl        = (!leap || (dday5_q <= 10'd59)) ? dday5_q : dday5_q - 10'd1;
    mon       = 4'd12;
    for (int m = 11; m >= 1; m--) begin
      if (10'(month_start(4'(m))) > nl) begin
        mon = 4'(m);
      end
    end
    if (feb29) begin
      mon = 4'd2;
    end
    time6_d = {hrs5_q, mins5_q, secs_full[5:1]};
    date6_d = 16'(nl) - 16'(month_start(mon - 4'd1)) + 16'd1 + 16'({mon, 5'b0})
            + 16'({year5_q, 9'b0});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      u0_q <= u0_d;
    end
    if (ctrl_i.en[1]) begin
      u1_q  <= u0_q;
      qd1_q <= dprod[48:34];
    end
    if (ctrl_i.en[2]) begin
      rem2_q <= rem2_full[16:0];
      day2_q <= qd1_q - DaysTo1980;
    end
    if (ctrl_i.en[3]) begin
      rem3_q  <= rem2_q;
      day3_q  <= day2_q;
      hrs3_q  <= hprod[25:21];
      year3_q <= yprod[29:24];
    end
    if (ctrl_i.en[4]) begin
      rem4_q  <= rem4_full[11:0];
      hrs4_q  <= hrs3_q;
      year4_q <= year3_q;
      day4_q  <= day3_q;
      bef4_q  <= years_before(year3_q);
    end
    if (ctrl_i.en[5]) begin
      rem5_q  <= rem4_q;
      hrs5_q  <= hrs4_q;
      mins5_q <= mprod[19:14];
      year5_q <= year5_d;
      dday5_q <= dday5_full[9:0];
    end
    if (ctrl_i.en[NumStages-1]) begin
      time6_q <= time6_d;
      date6_q <= date6_d;
    end
  end

  assign dos_time_o = time6_q;
  assign dos_date_o = date6_q;

endmodule

`default_nettype wire

@@ sv/dos_unix_timestamp_convert.sv @@
// Converts FAT packed time/date words to signed 32-bit Unix seconds or back,
// the direction picked by the operation bit of each item. One item is taken
// per clock while the output does not stall, and each result is offered
// from the last pipeline stage; the depth is set by the chain of reciprocal
// multiplies that splits Unix seconds into days, hours, minutes and years,
// and the other direction is delayed to the same depth so results leave in
// order. A stalled output holds its result while empty stages further up
// keep filling. The timezone register is stored already multiplied by 60
// at the write and must only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module dos_unix_timestamp_convert (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               tz_we_i,
  input  wire logic signed [11:0] tz_wdata_i,
  ducv_in_if.sink                 in_i,
  ducv_out_if.source              out_o
);
  import ducv_pkg::*;

  ducv_ctrl_t  ctrl;
  logic [31:0] tz_off_q;
  logic [31:0] d2u_res;
  logic [15:0] u2d_time;
  logic [15:0] u2d_date;
  ducv_op_e    in_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_off_q <= '0;
    end else if (tz_we_i) begin
      tz_off_q <= 32'(tz_wdata_i) * 32'(SecsPerMin);
    end
  end

  assign in_op = ducv_op_e'(in_i.operation);

  ducv_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_op),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .ctrl_o      (ctrl)
  );

  ducv_d2u u_d2u (
    .clk_i,
    .ctrl_i     (ctrl),
    .dos_time_i (in_i.dos_time),
    .dos_date_i (in_i.dos_date),
    .tz_off_i   (tz_off_q),
    .result_o   (d2u_res)
  );

  ducv_u2d u_u2d (
    .clk_i,
    .ctrl_i         (ctrl),
    .unix_seconds_i (in_i.unix_seconds),
    .tz_off_i       (tz_off_q),
    .dos_time_o     (u2d_time),
    .dos_date_o     (u2d_date)
  );

  // fields of the direction not taken read as zero
  assign out_o.valid            = ctrl.last_valid;
  assign out_o.unix_seconds_out = (ctrl.last_op == OpDosToUnix) ? $signed(d2u_res) : '0;
  assign out_o.dos_time_out     = (ctrl.last_op == OpUnixToDos) ? u2d_time : '0;
  assign out_o.dos_date_out     = (ctrl.last_op == OpUnixToDos) ? u2d_date : '0;

endmodule

`default_nettype wire

@@ sv/ducv_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ducv_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] unix_seconds_out_i,
  input wire logic [15:0] dos_time_out_i,
  input wire logic [15:0] dos_date_out_i
);

  // a result waiting for transfer stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(unix_seconds_out_i)
      && $stable(dos_time_out_i) && $stable(dos_date_out_i))
    else $error("stalled result changed");

  // a packed date never has day zero, so it marks the direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (dos_date_out_i != 16'd0) |-> (unix_seconds_out_i == 32'd0))
    else $error("both directions present in one result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (dos_date_out_i != 16'd0) |->
      (dos_time_out_i[15:11] <= 5'd23) && (dos_time_out_i[10:5] <= 6'd59)
      && (dos_time_out_i[4:0] <= 5'd29) && (dos_date_out_i[8:5] != 4'd0)
      && (dos_date_out_i[8:5] <= 4'd12) && (dos_date_out_i[15:9] <= 7'd58))
    else $error("packed time or date field out of range");

endmodule

bind dos_unix_timestamp_convert ducv_chk u_ducv_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .unix_seconds_out_i (out_o.unix_seconds_out),
  .dos_time_out_i     (out_o.dos_time_out),
  .dos_date_out_i     (out_o.dos_date_out)
);

`default_nettype wire

@@ tb/dos_unix_timestamp_convert_tb.sv @@
`timescale 1ns / 1ps

module dos_unix_timestamp_convert_tb;
  import ducv_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned RandPerPhase  = 230;

  localparam logic [31:0] MonthDays [16] = '{
    32'd0, 32'd31, 32'd59, 32'd90, 32'd120, 32'd151, 32'd181, 32'd212,
    32'd243, 32'd273, 32'd304, 32'd334, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    ducv_op_e           op;
    logic [15:0]        dos_time;
    logic [15:0]        dos_date;
    logic signed [31:0] unix_seconds;
  } stamp_item_t;

  typedef struct packed {
    logic signed [31:0] unix_seconds;
    logic [15:0]        dos_time;
    logic [15:0]        dos_date;
  } stamp_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic tz_we = 1'b0;
  logic signed [11:0] tz_wdata = 12'sd0;

  ducv_in_if  in_bus ();
  ducv_out_if out_bus ();

  dos_unix_timestamp_convert u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tz_we_i    (tz_we),
    .tz_wdata_i (tz_wdata),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  stamp_item_t        pending_stamps [$];
  stamp_res_t         expected_stamps [$];
  logic signed [11:0] tz_model = 12'sd0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int                 holdoff_req = -1;
  int                 holdoff_seen = -1;
  int unsigned        hold_cnt = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        errors = 0;
  logic               in_fire_q = 1'b0;
  stamp_item_t        drv_item;
  stamp_item_t        seen_item;
  stamp_res_t         want_res;
  stamp_res_t         got_res;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] tz_secs(input logic signed [11:0] tz);
    return 32'(int'(tz) * 60);
  endfunction

  function automatic stamp_res_t predict_stamp(input stamp_item_t it,
                                               input logic signed [11:0] tz);
    logic [31:0] off, mon, yr, days, u, dy, yrs, bef_days, nl, mo;
    stamp_res_t  r;
    off = tz_secs(tz);
    r   = '0;
    if (it.op == OpDosToUnix) begin
      // month field zero wraps to table entry 15
      mon  = {28'd0, it.dos_date[8:5] - 4'd1};
      yr   = {25'd0, it.dos_date[15:9]};
      days = {27'd0, it.dos_date[4:0]} - 32'd1 + MonthDays[mon[3:0]] + yr / 32'd4
           + yr * 32'd365 - (((yr[1:0] == 2'd0) && (mon < 32'd2)) ? 32'd1 : 32'd0)
           + 32'd3653;
      r.unix_seconds = {27'd0, it.dos_time[4:0]} * 32'd2
                     + 32'd60 * {26'd0, it.dos_time[10:5]}
                     + {27'd0, it.dos_time[15:11]} * 32'd3600
                     + 32'd86400 * days + off;
    end else begin
      u = it.unix_seconds - off;
      if (u[31] || u < 32'd315532800) u = 32'd315532800;
      r.dos_time = 16'((u % 32'd60) / 32'd2 + (((u / 32'd60) % 32'd60) << 5)
                 + (((u / 32'd3600) % 32'd24) << 11));
      dy       = u / 32'd86400 - 32'd3652;
      yrs      = dy / 32'd365;
      bef_days = (yrs + 32'd3) / 32'd4 + 32'd365 * yrs;
      if (bef_days > dy && yrs > 32'd0) begin
        yrs      = yrs - 32'd1;
        bef_days = (yrs + 32'd3) / 32'd4 + 32'd365 * yrs;
      end
      dy = dy - bef_days;
      if (dy == 32'd59 && yrs[1:0] == 2'd0) begin
        // leap day
        nl = dy;
        mo = 32'd2;
      end else begin
        nl = (yrs[1:0] != 2'd0 || dy <= 32'd59) ? dy : dy - 32'd1;
        mo = 32'd1;
        while (mo < 32'd12 && MonthDays[mo[3:0]] <= nl) mo = mo + 32'd1;
      end
      r.dos_date = 16'(nl - MonthDays[4'(mo - 32'd1)] + 32'd1 + (mo << 5) + (yrs << 9));
    end
    return r;
  endfunction

  function automatic stamp_item_t random_stamp(input logic signed [11:0] tz);
    stamp_item_t it;
    int unsigned sel;
    int unsigned yy;
    logic [31:0] base;
    sel             = $urandom_range(0, 9);
    yy              = $urandom_range(0, 58);
    it.op           = ducv_op_e'($urandom_range(0, 1));
    it.dos_time     = 16'($urandom);
    it.dos_date     = 16'($urandom);
    it.unix_seconds = 32'($urandom);
    base = 32'd315532800 + 32'(yy * 365 + (yy + 3) / 4) * 32'd86400 + tz_secs(tz);
    if (sel < 6) begin
      // well-formed words and seconds from shortly before 1980 to the top of the range
      it.dos_time = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                     5'($urandom_range(0, 29))};
      it.dos_date = {7'($urandom_range(0, 127)), 4'($urandom_range(1, 12)),
                     5'($urandom_range(1, 31))};
      it.unix_seconds = 32'($urandom_range(32'd315432800, 32'h7fffffff));
    end else if (sel == 6) begin
      // around a new year
      it.unix_seconds = base + 32'($urandom_range(0, 7200)) - 32'd3600;
    end else if (sel == 7) begin
      // around the end of february
      it.unix_seconds = base + 32'($urandom_range(58, 60)) * 32'd86400
                      + 32'($urandom_range(0, 86399));
    end
    return it;
  endfunction

  task automatic add_dos(input logic [15:0] t, input logic [15:0] d);
    pending_stamps.push_back('{OpDosToUnix, t, d, 32'sd0});
  endtask

  task automatic add_unix(input logic [31:0] u);
    pending_stamps.push_back('{OpUnixToDos, 16'd0, 16'd0, u});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_stamps.size() != 0 || in_bus.valid || expected_stamps.size() != 0);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire_q) begin
      if (pending_stamps.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = pending_stamps.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.operation    <= drv_item.op;
        in_bus.dos_time     <= drv_item.dos_time;
        in_bus.dos_date     <= drv_item.dos_date;
        in_bus.unix_seconds <= drv_item.unix_seconds;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        hold_cnt     = HoldOffCycles;
      end
      if (hold_cnt != 0) begin
        hold_cnt      = hold_cnt - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire_q <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        seen_item = '{ducv_op_e'(in_bus.operation), in_bus.dos_time, in_bus.dos_date,
                      in_bus.unix_seconds};
        expected_stamps.push_back(predict_stamp(seen_item, tz_model));
      end
      if (out_bus.valid && out_bus.ready) begin
        got_res = '{out_bus.unix_seconds_out, out_bus.dos_time_out, out_bus.dos_date_out};
        if (expected_stamps.size() == 0) begin
          errors++;
          $display("%0t unexpected result: unix %h time %h date %h", $realtime,
                   got_res.unix_seconds, got_res.dos_time, got_res.dos_date);
        end else begin
          want_res = expected_stamps.pop_front();
          if (got_res.unix_seconds !== want_res.unix_seconds
              || got_res.dos_time !== want_res.dos_time
              || got_res.dos_date !== want_res.dos_date) begin
            errors++;
            $display("%0t mismatch: expected unix %h time %h date %h, actual unix %h time %h date %h",
                     $realtime, want_res.unix_seconds, want_res.dos_time, want_res.dos_date,
                     got_res.unix_seconds, got_res.dos_time, got_res.dos_date);
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic signed [11:0] tz_pick [NumPhases];
    int unsigned        send_pick [NumPhases];
    int unsigned        recv_pick [NumPhases];

    in_bus.valid        = 1'b0;
    in_bus.operation    = 1'b0;
    in_bus.dos_time     = 16'd0;
    in_bus.dos_date     = 16'd0;
    in_bus.unix_seconds = 32'sd0;
    out_bus.ready       = 1'b0;

    tz_pick   = '{12'sd0, -12'sd1440, 12'sd1440, 12'($urandom_range(0, 2880) - 1440),
                  12'($urandom_range(0, 2880) - 1440)};
    send_pick = '{0, 46, 0, 38, 0};
    recv_pick = '{0, 0, 46, 38, 0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      tz_we    <= 1'b1;
      tz_wdata <= tz_pick[p];
      @(negedge clk_i);
      tz_we    <= 1'b0;
      tz_model  = tz_pick[p];
      @(posedge clk_i);
      send_idle_pct  = send_pick[p];
      recv_stall_pct = recv_pick[p];
      // receiver holds off while the sender keeps offering
      if (p == 2) holdoff_req = p;

      if (p == 0) begin
        add_dos(16'h0000, 16'h0000);
        add_dos(16'hffff, 16'hffff);
        add_dos(16'h0000, {7'd0, 4'd1, 5'd1});
        add_dos({5'd23, 6'd59, 5'd29}, {7'd0, 4'd2, 5'd29});
        add_dos(16'h0000, {7'd4, 4'd2, 5'd29});
        add_dos(16'h0000, {7'd4, 4'd3, 5'd1});
        add_dos(16'h0000, {7'd5, 4'd13, 5'd10});
        add_dos(16'h0000, {7'd3, 4'd15, 5'd31});
        add_dos(16'h0000, {7'd8, 4'd0, 5'd15});
        add_dos(16'h1234, {7'd10, 4'd6, 5'd0});
        add_dos({5'd31, 6'd63, 5'd31}, {7'd20, 4'd7, 5'd4});
        add_dos({5'd23, 6'd59, 5'd29}, {7'd127, 4'd12, 5'd31});
        add_unix(32'h8000_0000);
        add_unix(32'h7fff_ffff);
        add_unix(32'h0000_0000);
        add_unix(32'hffff_ffff);
        add_unix(32'd315532799);
        add_unix(32'd315532800);
        add_unix(32'd315532800 + 32'd59 * 32'd86400);
        add_unix(32'd315532800 + 32'd60 * 32'd86400);
        add_unix(32'd315532800 + 32'd365 * 32'd86400);
        add_unix(32'd315532800 + 32'd1520 * 32'd86400 + 32'd86399);
        add_unix(32'd315532800 + 32'd1521 * 32'd86400);
      end else begin
        // offset removal wraps at both ends
        add_unix(32'h8000_0000);
        add_unix(32'h7fff_ffff);
      end
      for (int i = 0; i < RandPerPhase; i++) begin
        pending_stamps.push_back(random_stamp(tz_model));
      end
    end

    wait_drained();
    repeat (NumStages + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ducv_pkg.sv
sv/ducv_if.sv
sv/ducv_ctrl.sv
sv/ducv_d2u.sv
sv/ducv_u2d.sv
sv/dos_unix_timestamp_convert.sv
sv/ducv_chk.sv
tb/dos_unix_timestamp_convert_tb.sv
